// File: rtl/vfc_pkg.sv
// Shared widths, codes and controller/datapath interface types for the curl block.
package vfc_pkg;

  // Default grid limits per axis
  localparam int DEF_MAX_SIZE_X = 16;
  localparam int DEF_MAX_SIZE_Y = 16;
  localparam int DEF_MAX_SIZE_Z = 16;

  // Field widths
  localparam int POS_W     = 4;
  localparam int FIELD_W   = 16;
  localparam int DIFF_W    = FIELD_W + 1;
  localparam int CURL_W    = FIELD_W + 2;
  localparam int SIZE_W    = 5;
  localparam int EXT_W     = 9;   // holds any size limit up to 256
  localparam int CFG_IDX_W = 2;
  localparam int VEC_W     = 3 * FIELD_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = CFG_IDX_W'(2);

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_RD_X,
    ST_RD_Y,
    ST_RD_Z,
    ST_LAST,
    ST_DONE
  } state_e;

  // Store address select
  typedef enum logic [1:0] {
    SEL_OWN,
    SEL_NX,
    SEL_NY,
    SEL_NZ
  } addr_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic      capture;
    logic      mem_we;
    logic      mem_re;
    addr_sel_e sel;
    logic      ld_own;
    logic      ld_dx;
    logic      ld_dy;
    logic      ld_dz;
    logic      ld_out;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_read;
    logic oor;
  } dp_status_t;

endpackage

// File: rtl/vfc_ctrl.sv
// Controller state machine: sequences store accesses and owns the output beat.
module vfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  vfc_pkg::dp_status_t status_i,
  output vfc_pkg::ctrl_cmd_t  cmd_o
);
  import vfc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (!status_i.is_read) state_d = ST_IDLE;
        else if (status_i.oor) state_d = ST_DONE;
        else state_d = ST_RD_X;
      end
      ST_RD_X: state_d = ST_RD_Y;
      ST_RD_Y: state_d = ST_RD_Z;
      ST_RD_Z: state_d = ST_LAST;
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.sel = SEL_OWN;
    case (state_q)
      ST_IDLE: cmd_o.capture = in_valid_i;
      ST_ISSUE: begin
        cmd_o.mem_we = !status_i.is_read && !status_i.oor;
        cmd_o.mem_re = status_i.is_read && !status_i.oor;
        cmd_o.sel    = SEL_OWN;
      end
      ST_RD_X: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.sel    = SEL_NX;
        cmd_o.ld_own = 1'b1;
      end
      ST_RD_Y: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.sel    = SEL_NY;
        cmd_o.ld_dx  = 1'b1;
      end
      ST_RD_Z: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.sel    = SEL_NZ;
        cmd_o.ld_dy  = 1'b1;
      end
      ST_LAST: cmd_o.ld_dz = 1'b1;
      ST_DONE: cmd_o.ld_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Output beat: set on load, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/vfc_dpath.sv
// Datapath: size registers, item registers, voxel store, differences and output register.
module vfc_dpath #(
  parameter int MAX_SIZE_X = vfc_pkg::DEF_MAX_SIZE_X,
  parameter int MAX_SIZE_Y = vfc_pkg::DEF_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z = vfc_pkg::DEF_MAX_SIZE_Z
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [vfc_pkg::SIZE_W-1:0]               cfg_data_i,
  input  vfc_pkg::ctrl_cmd_t                       cmd_i,
  output vfc_pkg::dp_status_t                      status_o,
  input  logic                                     command_i,
  input  logic [vfc_pkg::POS_W-1:0]                pos_x_i,
  input  logic [vfc_pkg::POS_W-1:0]                pos_y_i,
  input  logic [vfc_pkg::POS_W-1:0]                pos_z_i,
  input  logic signed [vfc_pkg::FIELD_W-1:0]       field_x_i,
  input  logic signed [vfc_pkg::FIELD_W-1:0]       field_y_i,
  input  logic signed [vfc_pkg::FIELD_W-1:0]       field_z_i,
  output logic signed [vfc_pkg::CURL_W-1:0]        curl_x_o,
  output logic signed [vfc_pkg::CURL_W-1:0]        curl_y_o,
  output logic signed [vfc_pkg::CURL_W-1:0]        curl_z_o,
  output logic                                     out_of_range_o
);
  import vfc_pkg::*;

  // Address bits per axis: enough for the limit, never more than a position carries
  localparam int XW    = (MAX_SIZE_X > (1 << POS_W)) ? POS_W : $clog2(MAX_SIZE_X);
  localparam int YW    = (MAX_SIZE_Y > (1 << POS_W)) ? POS_W : $clog2(MAX_SIZE_Y);
  localparam int ZW    = (MAX_SIZE_Z > (1 << POS_W)) ? POS_W : $clog2(MAX_SIZE_Z);
  localparam int AW    = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [EXT_W-1:0]  ext_x, ext_y, ext_z;
  logic [EXT_W-1:0]  px, py, pz;
  logic              last_x, last_y, last_z, last_sel;

  logic              cmd_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [VEC_W-1:0]  wdata_q;

  logic [VEC_W-1:0]  mem_q [DEPTH];
  logic [VEC_W-1:0]  rdata_q, own_q;
  logic [XW-1:0]     ax, ax_n;
  logic [YW-1:0]     ay, ay_n;
  logic [ZW-1:0]     az, az_n;
  logic [AW-1:0]     addr;

  logic signed [DIFF_W-1:0] diff   [3];
  logic signed [DIFF_W-1:0] dx_q   [3];
  logic signed [DIFF_W-1:0] dy_q   [3];
  logic signed [DIFF_W-1:0] dz_q   [3];
  logic signed [CURL_W-1:0] curl_x_q, curl_y_q, curl_z_q;
  logic                     oor_q;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIZE_X: size_x_q <= cfg_data_i;
        CFG_SIZE_Y: size_y_q <= cfg_data_i;
        CFG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      wdata_q <= {field_z_i, field_y_i, field_x_i};
    end
  end

  // Effective sizes and range checks
  assign ext_x = (EXT_W'(size_x_q) > EXT_W'(MAX_SIZE_X)) ? EXT_W'(MAX_SIZE_X) : EXT_W'(size_x_q);
  assign ext_y = (EXT_W'(size_y_q) > EXT_W'(MAX_SIZE_Y)) ? EXT_W'(MAX_SIZE_Y) : EXT_W'(size_y_q);
  assign ext_z = (EXT_W'(size_z_q) > EXT_W'(MAX_SIZE_Z)) ? EXT_W'(MAX_SIZE_Z) : EXT_W'(size_z_q);
  assign px = EXT_W'(pos_x_q);
  assign py = EXT_W'(pos_y_q);
  assign pz = EXT_W'(pos_z_q);

  assign status_o.is_read = (cmd_q == CMD_READ);
  assign status_o.oor     = (px >= ext_x) || (py >= ext_y) || (pz >= ext_z);

  assign last_x = (px + EXT_W'(1) == ext_x);
  assign last_y = (py + EXT_W'(1) == ext_y);
  assign last_z = (pz + EXT_W'(1) == ext_z);

  // Store address: own voxel or the next one along an axis (own on the last plane)
  assign ax   = pos_x_q[XW-1:0];
  assign ay   = pos_y_q[YW-1:0];
  assign az   = pos_z_q[ZW-1:0];
  assign ax_n = last_x ? ax : ax + XW'(1);
  assign ay_n = last_y ? ay : ay + YW'(1);
  assign az_n = last_z ? az : az + ZW'(1);

  always_comb begin
    case (cmd_i.sel)
      SEL_OWN: addr = {ax, ay, az};
      SEL_NX:  addr = {ax_n, ay, az};
      SEL_NY:  addr = {ax, ay_n, az};
      SEL_NZ:  addr = {ax, ay, az_n};
      default: addr = {ax, ay, az};
    endcase
  end

  // Single-port voxel store with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem_q[addr] <= wdata_q;
    if (cmd_i.mem_re) rdata_q <= mem_q[addr];
  end

  // Partial vector: own minus neighbor, or own alone on the last plane
  assign last_sel = cmd_i.ld_dx ? last_x : (cmd_i.ld_dy ? last_y : last_z);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = {own_q[c*FIELD_W + FIELD_W-1], own_q[c*FIELD_W +: FIELD_W]};
      if (!last_sel) begin
        diff[c] = diff[c]
                - {rdata_q[c*FIELD_W + FIELD_W-1], rdata_q[c*FIELD_W +: FIELD_W]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_own) own_q <= rdata_q;
    if (cmd_i.ld_dx) dx_q <= diff;
    if (cmd_i.ld_dy) dy_q <= diff;
    if (cmd_i.ld_dz) dz_q <= diff;
  end

  // Output register: curl, or zeros with the flag on an out-of-range read
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      oor_q <= status_o.oor;
      if (status_o.oor) begin
        curl_x_q <= '0;
        curl_y_q <= '0;
        curl_z_q <= '0;
      end else begin
        curl_x_q <= CURL_W'(dy_q[2]) - CURL_W'(dz_q[1]);
        curl_y_q <= CURL_W'(dz_q[0]) - CURL_W'(dx_q[2]);
        curl_z_q <= CURL_W'(dx_q[1]) - CURL_W'(dy_q[0]);
      end
    end
  end

  assign curl_x_o       = curl_x_q;
  assign curl_y_o       = curl_y_q;
  assign curl_z_o       = curl_z_q;
  assign out_of_range_o = oor_q;

endmodule

// File: rtl/vector_field_curl_3d.sv
// Top level of the 3D curl block: ports, controller, datapath and checks.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one command per
// beat. A write stores a three-component vector at a grid position; a write
// outside the configured sizes is dropped. A read returns one beat on the
// output channel (out_valid_o / out_stall_i) with the curl from forward
// differences, or zeros with out_of_range_o set for a position outside the
// sizes. Writes produce no output beat.
// Timing: a read fetches the voxel and its three forward neighbors through the
// single port of the voxel store, one per cycle. An in-range read steps through
// ISSUE, RD_X, RD_Y, RD_Z, LAST and DONE, loads the output in DONE and takes the
// next beat back in IDLE; an out-of-range read jumps from ISSUE to DONE, a write to IDLE.
// The cfg channel (cfg_valid_i / cfg_ready_o) writes the size registers and is
// always ready; write it only while the block is idle.
// Reset clears the controller and sets every size to 16; the store is not
// cleared, so read a voxel only after writing it. When the receiver stalls,
// the result is held in the output register; the block keeps taking writes and
// one more read, and stalls that read at its end until the output frees up.
module vector_field_curl_3d #(
  parameter int MAX_SIZE_X = vfc_pkg::DEF_MAX_SIZE_X,
  parameter int MAX_SIZE_Y = vfc_pkg::DEF_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z = vfc_pkg::DEF_MAX_SIZE_Z
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vfc_pkg::SIZE_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic [vfc_pkg::POS_W-1:0]          pos_x_i,
  input  logic [vfc_pkg::POS_W-1:0]          pos_y_i,
  input  logic [vfc_pkg::POS_W-1:0]          pos_z_i,
  input  logic signed [vfc_pkg::FIELD_W-1:0] field_x_i,
  input  logic signed [vfc_pkg::FIELD_W-1:0] field_y_i,
  input  logic signed [vfc_pkg::FIELD_W-1:0] field_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vfc_pkg::CURL_W-1:0]  curl_x_o,
  output logic signed [vfc_pkg::CURL_W-1:0]  curl_y_o,
  output logic signed [vfc_pkg::CURL_W-1:0]  curl_z_o,
  output logic                               out_of_range_o
);
  import vfc_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  vfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  vfc_dpath #(
    .MAX_SIZE_X (MAX_SIZE_X),
    .MAX_SIZE_Y (MAX_SIZE_Y),
    .MAX_SIZE_Z (MAX_SIZE_Z)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .command_i      (command_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .field_x_i      (field_x_i),
    .field_y_i      (field_y_i),
    .field_z_i      (field_z_i),
    .curl_x_o       (curl_x_o),
    .curl_y_o       (curl_y_o),
    .curl_z_o       (curl_z_o),
    .out_of_range_o (out_of_range_o)
  );

  // An accepted beat keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // The store is written only for an in-range write command
  a_write_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.mem_we |-> (!dp_status.is_read && !dp_status.oor))
    else $error("store written outside an in-range write");

  // An out-of-range result carries a zero curl
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |->
      (curl_x_o == '0 && curl_y_o == '0 && curl_z_o == '0))
    else $error("out-of-range result with nonzero curl");

  // Loading the output register always presents a beat
  a_load_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.ld_out |=> out_valid_o)
    else $error("output load without a valid beat");

endmodule
